>>> rtl/core/ecs_pkg.sv
// ----------------------------------------------------------------------------
// ecs_pkg : shared types and constants for the edge coverage setup block
// Fixed result widths, sub-pixel constants and the side-band record that
// travels with each transaction through the divider pipeline.
// ----------------------------------------------------------------------------
package ecs_pkg;

   // result field widths
   localparam int POS_W = 18;
   localparam int INC_W = 23;
   localparam int BEG_W = 23;
   localparam int END_W = 24;

   // sub-pixel position: 1/64 pixel
   localparam int SUB_W   = 6;
   localparam int SUB_ONE = 64;

   // increment used when both samples are equal
   localparam int EQUAL_INC = 100;

   // scaling of the crossing-case products
   localparam int CROSS_SHIFT = 13;

   // per-transaction values carried alongside the division
   typedef struct packed {
      logic [POS_W-1:0]   pos;    // lower sample, truncated to result width
      logic [SUB_W-1:0]   lf;     // fraction of the lower sample
      logic [SUB_W-1:0]   hf;     // fraction of the upper sample
      logic [SUB_W-2:0]   dhalf;  // difference / 2, meaningful in one pixel only
      logic [2*SUB_W-1:0] hf2;    // hf squared
      logic               same;   // both samples inside one pixel
      logic               dzero;  // samples equal
   } side_type;

endpackage

>>> rtl/core/ecs_div.sv
// ----------------------------------------------------------------------------
// ecs_div : pipelined restoring divider, (1 << NUM_SHIFT) / divisor
// STEP_BITS quotient bits are resolved in each register stage; a new
// transaction may enter every cycle. The side-band record travels along.
// ----------------------------------------------------------------------------
module ecs_div #(
   parameter int DIV_W     = 18,
   parameter int NUM_SHIFT = 22,
   parameter int STEP_BITS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  in_divisor,
   input  ecs_pkg::side_type in_side,
   output logic              out_valid,
   output logic [NUM_SHIFT:0] out_quotient,
   output ecs_pkg::side_type out_side
);
   import ecs_pkg::*;

   // enough stages to cover NUM_SHIFT+1 quotient bits
   localparam int NUM_STAGES = (NUM_SHIFT + STEP_BITS) / STEP_BITS;
   localparam int QUO_W      = NUM_STAGES * STEP_BITS;

   logic             valid_ff [NUM_STAGES];
   logic [DIV_W-1:0] rem_ff   [NUM_STAGES];
   logic [QUO_W-1:0] quo_ff   [NUM_STAGES];
   logic [DIV_W-1:0] div_ff   [NUM_STAGES];
   side_type         side_ff  [NUM_STAGES];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      logic             valid_src;
      logic [DIV_W-1:0] rem_src;
      logic [QUO_W-1:0] quo_src;
      logic [DIV_W-1:0] div_src;
      side_type         side_src;
      logic [DIV_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      // stage input: ports for the first stage, previous stage otherwise
      if (s == 0) begin : g_head
         assign valid_src = in_valid;
         assign rem_src   = '0;
         assign quo_src   = '0;
         assign div_src   = in_divisor;
         assign side_src  = in_side;
      end else begin : g_body
         assign valid_src = valid_ff[s-1];
         assign rem_src   = rem_ff[s-1];
         assign quo_src   = quo_ff[s-1];
         assign div_src   = div_ff[s-1];
         assign side_src  = side_ff[s-1];
      end

      // STEP_BITS shift-compare-subtract steps
      always_comb begin
         logic [DIV_W:0] trial;
         logic           num_bit;
         rem_in  = rem_src;
         quo_in  = quo_src;
         trial   = '0;
         num_bit = 1'b0;
         for (int j = 0; j < STEP_BITS; j++) begin
            num_bit = ((QUO_W - 1 - (s * STEP_BITS + j)) == NUM_SHIFT);
            trial   = {rem_in, num_bit};
            if (trial >= {1'b0, div_src}) begin
               rem_in = DIV_W'(trial - {1'b0, div_src});
               quo_in = {quo_in[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DIV_W-1:0];
               quo_in = {quo_in[QUO_W-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[s]  <= rem_in;
         quo_ff[s]  <= quo_in;
         div_ff[s]  <= div_src;
         side_ff[s] <= side_src;
      end
   end

   assign out_valid    = valid_ff[NUM_STAGES-1];
   assign out_quotient = quo_ff[NUM_STAGES-1][NUM_SHIFT:0];
   assign out_side     = side_ff[NUM_STAGES-1];

endmodule

>>> rtl/core/edge_coverage_setup_top.sv
// ----------------------------------------------------------------------------
// edge_coverage_setup_top : coverage setup for one pair of edge samples
// Sorts the two samples, divides for the per-pixel increment and forms the
// begin and end coverage adders in unsigned Q7.16 (signed Q8.16 for the end).
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_edge_a / req_edge_b with start high; the transaction is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only while reset is held, so one pair can be taken every cycle.
//   Output: each result is on the rsp_ ports for exactly one cycle, marked
//   by rsp_valid. Results leave in the order their pairs arrived.
//   A transaction passes one sorting stage, then the pipelined divider,
//   which resolves four quotient bits per stage, then the product stages
//   and the output stage.
//   Throughput: one transaction per cycle, sustained.
//   Reset clears every valid bit in the pipeline; transactions in flight are
//   dropped and no result appears in the cycle after reset.
//   The receiver cannot hold results off, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module edge_coverage_setup_top #(
   parameter int COORD_BITS = 18,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [COORD_BITS-1:0]               req_edge_a,
   input  logic [COORD_BITS-1:0]               req_edge_b,
   output logic                                rsp_valid,
   output logic [ecs_pkg::POS_W-1:0]           rsp_start_pos,
   output logic [ecs_pkg::INC_W-1:0]           rsp_increment,
   output logic [ecs_pkg::BEG_W-1:0]           rsp_begin_adder,
   output logic signed [ecs_pkg::END_W-1:0]    rsp_end_adder
);
   import ecs_pkg::*;

   // derived widths
   localparam int NUM_SHIFT = FRAC_BITS + SUB_W;          // dividend 64 << F
   localparam int IW        = FRAC_BITS + 7;              // holds 100 << F
   localparam int W_W       = IW + SUB_W + 1 - FRAC_BITS; // (inc * h) >> F
   localparam int HW_W      = SUB_W + 1 + W_W;            // h * w
   localparam int FIRST_W   = HW_W + FRAC_BITS - CROSS_SHIFT;
   localparam int SP_W      = FRAC_BITS + 1;              // same-pixel first term
   localparam int BSUM_W    = ((IW > FIRST_W) ? IW : FIRST_W) + 1;
   localparam int SAT_W     = (BSUM_W > INC_W + 1) ? BSUM_W : INC_W + 1;
   localparam int END_SW    = (IW + 1 > END_W + 1) ? IW + 1 : END_W + 1;

   // saturation limits and the equal-sample increment
   localparam logic [SAT_W-1:0] INC_MAX = SAT_W'((longint'(1) << INC_W) - 1);
   localparam logic [SAT_W-1:0] BEG_MAX = SAT_W'((longint'(1) << BEG_W) - 1);
   localparam logic signed [END_SW-1:0] END_HI =
      END_SW'((longint'(1) << (END_W - 1)) - 1);
   localparam logic signed [END_SW-1:0] END_LO =
      END_SW'(-(longint'(1) << (END_W - 1)));
   localparam logic [IW-1:0] EQUAL_Q = IW'(longint'(EQUAL_INC) << FRAC_BITS);

   // ------------------------------------------------------------------------
   // sort stage
   // ------------------------------------------------------------------------
   logic                  accept;
   logic [COORD_BITS-1:0] lo;
   logic [COORD_BITS-1:0] hi;
   logic [COORD_BITS-1:0] diff;
   side_type              pre_side_in;

   logic                  pre_valid_ff;
   logic [COORD_BITS-1:0] pre_d_ff;
   side_type              pre_side_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_comb begin
      if (req_edge_a < req_edge_b) begin
         lo = req_edge_a;
         hi = req_edge_b;
      end else begin
         lo = req_edge_b;
         hi = req_edge_a;
      end
      diff              = hi - lo;
      pre_side_in.pos   = POS_W'(lo);
      pre_side_in.lf    = lo[SUB_W-1:0];
      pre_side_in.hf    = hi[SUB_W-1:0];
      pre_side_in.dhalf = diff[SUB_W-1:1];
      pre_side_in.hf2   = {{SUB_W{1'b0}}, hi[SUB_W-1:0]} *
                          {{SUB_W{1'b0}}, hi[SUB_W-1:0]};
      pre_side_in.same  = (hi[COORD_BITS-1:SUB_W] == lo[COORD_BITS-1:SUB_W]);
      pre_side_in.dzero = (req_edge_a == req_edge_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else begin
         pre_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      pre_d_ff    <= diff;
      pre_side_ff <= pre_side_in;
   end

   // ------------------------------------------------------------------------
   // increment division: (64 << F) / d
   // ------------------------------------------------------------------------
   logic             div_valid;
   logic [NUM_SHIFT:0] div_quo;
   side_type         div_side;

   ecs_div #(
      .DIV_W     (COORD_BITS),
      .NUM_SHIFT (NUM_SHIFT)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pre_valid_ff),
      .in_divisor   (pre_d_ff),
      .in_side      (pre_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quo),
      .out_side     (div_side)
   );

   // ------------------------------------------------------------------------
   // product stage 1: increment times the fractions
   // ------------------------------------------------------------------------
   logic [IW-1:0]           inc_m1;
   logic [SUB_W:0]          h_m1;

   logic                    m1_valid_ff;
   logic [IW-1:0]           m1_inc_ff;
   logic [IW+SUB_W-1:0]     m1_plf_ff;
   logic [IW+SUB_W:0]       m1_ph_ff;
   logic [IW+SUB_W-1:0]     m1_phf_ff;
   logic [IW+2*SUB_W-1:0]   m1_phf2_ff;
   side_type                m1_side_ff;

   assign inc_m1 = div_side.dzero ? EQUAL_Q : IW'(div_quo);
   assign h_m1   = (SUB_W + 1)'(SUB_ONE) - {1'b0, div_side.lf};

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
      end else begin
         m1_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      m1_inc_ff  <= inc_m1;
      m1_plf_ff  <= (IW + SUB_W)'(inc_m1) * (IW + SUB_W)'(div_side.lf);
      m1_ph_ff   <= (IW + SUB_W + 1)'(inc_m1) * (IW + SUB_W + 1)'(h_m1);
      m1_phf_ff  <= (IW + SUB_W)'(inc_m1) * (IW + SUB_W)'(div_side.hf);
      m1_phf2_ff <= (IW + 2 * SUB_W)'(inc_m1) * (IW + 2 * SUB_W)'(div_side.hf2);
      m1_side_ff <= div_side;
   end

   // ------------------------------------------------------------------------
   // product stage 2: crossing area product, end difference, first terms
   // ------------------------------------------------------------------------
   logic [SUB_W:0]       h_m2;
   logic [W_W-1:0]       w_m2;
   logic [IW-1:0]        pa_m2;
   logic [IW-2:0]        pb_m2;
   logic [SUB_W:0]       sp_sum_m2;

   logic                 m2_valid_ff;
   logic [IW-1:0]        m2_inc_ff;
   logic [IW-1:0]        m2_base_ff;
   logic [HW_W-1:0]      m2_hw_ff;
   logic signed [IW:0]   m2_endx_ff;
   logic [SP_W-1:0]      m2_spf_ff;
   side_type             m2_side_ff;

   assign h_m2      = (SUB_W + 1)'(SUB_ONE) - {1'b0, m1_side_ff.lf};
   assign w_m2      = m1_ph_ff[IW+SUB_W:FRAC_BITS];
   assign pa_m2     = m1_phf_ff[IW+SUB_W-1:SUB_W];
   assign pb_m2     = m1_phf2_ff[IW+2*SUB_W-1:CROSS_SHIFT];
   assign sp_sum_m2 = (SUB_W + 1)'(SUB_ONE) - {1'b0, m1_side_ff.hf} +
                      {2'b00, m1_side_ff.dhalf};

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_valid_ff <= 1'b0;
      end else begin
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      m2_inc_ff  <= m1_inc_ff;
      m2_base_ff <= m1_plf_ff[IW+SUB_W-1:SUB_W];
      m2_hw_ff   <= HW_W'(h_m2) * HW_W'(w_m2);
      m2_endx_ff <= $signed({1'b0, pa_m2}) - $signed({2'b00, pb_m2});
      m2_spf_ff  <= SP_W'(sp_sum_m2) << (FRAC_BITS - SUB_W);
      m2_side_ff <= m1_side_ff;
   end

   // ------------------------------------------------------------------------
   // output stage: sum, select and saturate
   // ------------------------------------------------------------------------
   logic [HW_W+FRAC_BITS-1:0] hw_sh;
   logic [FIRST_W-1:0]        first_m3;
   logic [BSUM_W-1:0]         bsum_m3;
   logic [BEG_W-1:0]          beg_sat;
   logic [INC_W-1:0]          inc_sat;
   logic signed [END_SW-1:0]  endx_ext;
   logic signed [END_W-1:0]   end_sat;

   logic                      out_valid_ff;
   logic [POS_W-1:0]          out_pos_ff;
   logic [INC_W-1:0]          out_inc_ff;
   logic [BEG_W-1:0]          out_beg_ff;
   logic signed [END_W-1:0]   out_end_ff;

   always_comb begin
      hw_sh    = {m2_hw_ff, {FRAC_BITS{1'b0}}};
      first_m3 = m2_side_ff.same ? FIRST_W'(m2_spf_ff)
                                 : hw_sh[HW_W+FRAC_BITS-1:CROSS_SHIFT];
      bsum_m3  = BSUM_W'(m2_base_ff) + BSUM_W'(first_m3);

      // begin adder and increment saturate at the top of their range
      if (SAT_W'(bsum_m3) > BEG_MAX) begin
         beg_sat = BEG_MAX[BEG_W-1:0];
      end else begin
         beg_sat = BEG_W'(bsum_m3);
      end
      if (SAT_W'(m2_inc_ff) > INC_MAX) begin
         inc_sat = INC_MAX[INC_W-1:0];
      end else begin
         inc_sat = INC_W'(m2_inc_ff);
      end

      // end adder: copy of begin in one pixel, clamped difference otherwise
      endx_ext = END_SW'(m2_endx_ff);
      if (m2_side_ff.same) begin
         end_sat = $signed({1'b0, beg_sat});
      end else if (endx_ext > END_HI) begin
         end_sat = END_HI[END_W-1:0];
      end else if (endx_ext < END_LO) begin
         end_sat = END_LO[END_W-1:0];
      end else begin
         end_sat = endx_ext[END_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      out_pos_ff <= m2_side_ff.pos;
      out_inc_ff <= inc_sat;
      out_beg_ff <= beg_sat;
      out_end_ff <= end_sat;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_start_pos   = out_pos_ff;
   assign rsp_increment   = out_inc_ff;
   assign rsp_begin_adder = out_beg_ff;
   assign rsp_end_adder   = out_end_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
`ifndef SYNTHESIS
   // an accepted transaction always enters the sort stage
   a_accept_enters: assert property (@(posedge clock)
      accept |=> pre_valid_ff)
      else $error("accepted transaction missing from sort stage");

   // a finished division is never dropped on its way to the products
   a_div_to_m1: assert property (@(posedge clock) disable iff (reset)
      div_valid |=> m1_valid_ff)
      else $error("divider result lost before product stage");

   // the upper coverage term never exceeds the lower, so end is not negative
   a_end_nonneg: assert property (@(posedge clock)
      rsp_valid |-> !rsp_end_adder[END_W-1])
      else $error("negative end adder");

   // no transaction survives reset
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");
`endif

endmodule

>>> verif/edge_coverage_setup_top_tb.sv
// ----------------------------------------------------------------------------
// edge_coverage_setup_top_tb : self-checking bench for edge coverage setup
// A short table of hand-picked edge pairs is sent first, followed by a long
// run of random pairs grouped into classes: same pixel, equal, short spans,
// long spans and pairs near the coordinate ends. Each transaction is
// predicted in the bench, or taken from its table row, and checked field by field against the rsp_ ports.
// The sender works in bursts with random gaps between them.
// ----------------------------------------------------------------------------
module edge_coverage_setup_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ecs_pkg::*;

   localparam int COORD_BITS   = 18;
   localparam int FRAC_BITS    = 16;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int LATENCY      = 4 + (FRAC_BITS + 7 + 3) / 4;
   localparam int RANDOM_PAIRS = 1380;
   localparam int STALL_LIMIT  = 2000;
   localparam int REPORT_LIMIT = 10;
   localparam int N_DIRECTED   = 22;

   localparam longint unsigned Q16_MAX = (longint'(1) << INC_W) - 1;
   localparam longint END_MAX = (longint'(1) << (END_W - 1)) - 1;
   localparam longint END_MIN = -(longint'(1) << (END_W - 1));

   typedef struct packed {
      logic [POS_W-1:0] start_pos;
      logic [INC_W-1:0] increment;
      logic [BEG_W-1:0] begin_adder;
      logic [END_W-1:0] end_adder;
   } coverage_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] a;
      logic [COORD_BITS-1:0] b;
      logic                  typed;   // expectation written into the row
      coverage_type          want;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic [COORD_BITS-1:0] req_edge_a = '0;
   logic [COORD_BITS-1:0] req_edge_b = '0;
   logic busy;
   logic rsp_valid;
   logic [POS_W-1:0] rsp_start_pos;
   logic [INC_W-1:0] rsp_increment;
   logic [BEG_W-1:0] rsp_begin_adder;
   logic signed [END_W-1:0] rsp_end_adder;

   coverage_type pending_coverage[$];
   pair_row_type directed_rows [N_DIRECTED];
   int mismatch_count = 0;
   int stuck_cycles = 0;
   int burst_left = 0;

   edge_coverage_setup_top #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_edge_a     (req_edge_a),
      .req_edge_b     (req_edge_b),
      .rsp_valid      (rsp_valid),
      .rsp_start_pos  (rsp_start_pos),
      .rsp_increment  (rsp_increment),
      .rsp_begin_adder(rsp_begin_adder),
      .rsp_end_adder  (rsp_end_adder)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // saturate an unsigned Q7.16 value to the 23-bit field
   function automatic logic [INC_W-1:0] clamp_q16(input longint unsigned v);
      return (v > Q16_MAX) ? Q16_MAX[INC_W-1:0] : v[INC_W-1:0];
   endfunction

   // expected coverage setup for one edge pair
   function automatic coverage_type predict_coverage(input logic [COORD_BITS-1:0] edge_a,
                                                     input logic [COORD_BITS-1:0] edge_b);
      longint unsigned lo, hi, d, lf, hf, inc, span, wdt, first, begin_sum, pa, pb;
      longint endv;
      coverage_type r;
      lo = 64'((edge_a < edge_b) ? edge_a : edge_b);
      hi = 64'((edge_a < edge_b) ? edge_b : edge_a);
      d  = hi - lo;
      lf = lo & (SUB_ONE - 1);
      hf = hi & (SUB_ONE - 1);
      if (d == 0)
         inc = longint'(EQUAL_INC) << FRAC_BITS;
      else
         inc = (longint'(SUB_ONE) << FRAC_BITS) / d;
      if ((hi >> SUB_W) == (lo >> SUB_W)) begin
         // both samples inside one pixel
         first = ((SUB_ONE - hf) + (d >> 1)) << (FRAC_BITS - SUB_W);
         begin_sum = ((inc * lf) >> SUB_W) + first;
         endv = longint'(clamp_q16(begin_sum));
      end else begin
         // span crosses pixel boundaries
         span = SUB_ONE - lf;
         wdt = (inc * span) >> FRAC_BITS;
         first = ((span * wdt) << FRAC_BITS) >> CROSS_SHIFT;
         begin_sum = ((inc * lf) >> SUB_W) + first;
         pa = (hf * inc) >> SUB_W;
         pb = (hf * hf * inc) >> CROSS_SHIFT;
         endv = longint'(pa) - longint'(pb);
      end
      if (endv > END_MAX)
         endv = END_MAX;
      else if (endv < END_MIN)
         endv = END_MIN;
      r.start_pos   = lo[POS_W-1:0];
      r.increment   = clamp_q16(inc);
      r.begin_adder = clamp_q16(begin_sum);
      r.end_adder   = endv[END_W-1:0];
      return r;
   endfunction

   function automatic void note_mismatch(input string field, input logic [END_W-1:0] want_v,
                                         input logic [END_W-1:0] got_v);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want_v, got_v);
   endfunction

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      coverage_type want;
      if (!reset && rsp_valid !== 1'b0) begin
         if (pending_coverage.size() == 0) begin
            note_mismatch("unexpected result", '0, END_W'(rsp_start_pos));
         end else begin
            want = pending_coverage.pop_front();
            if (rsp_start_pos !== want.start_pos)
               note_mismatch("start_pos", END_W'(want.start_pos), END_W'(rsp_start_pos));
            if (rsp_increment !== want.increment)
               note_mismatch("increment", END_W'(want.increment), END_W'(rsp_increment));
            if (rsp_begin_adder !== want.begin_adder)
               note_mismatch("begin_adder", END_W'(want.begin_adder),
                             END_W'(rsp_begin_adder));
            if (rsp_end_adder !== want.end_adder)
               note_mismatch("end_adder", want.end_adder, rsp_end_adder);
         end
      end
   end

   // watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if ((start && busy === 1'b0) || rsp_valid === 1'b1)
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("edge_coverage_setup_top_tb NOT OK");
         $finish;
      end
   end

   // present one pair, hold it until taken, then queue its expectation
   task automatic send_pair(input logic [COORD_BITS-1:0] a, input logic [COORD_BITS-1:0] b,
                            input logic typed, input coverage_type want);
      start      <= 1'b1;
      req_edge_a <= a;
      req_edge_b <= b;
      do @(posedge clock); while (busy !== 1'b0);
      pending_coverage.push_back(typed ? want : predict_coverage(a, b));
   endtask

   // bursts of random length, random gaps in between
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 25);
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every outstanding result is back
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_coverage.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned a, b, delta, tmp;
      // a, b, typed, {start_pos, increment, begin_adder, end_adder}
      directed_rows = '{
         '{18'd0,      18'd0,      1'b1, '{18'd0,      23'd6553600, 23'd65536,   24'd65536}},
         '{18'd262143, 18'd262143, 1'b1, '{18'd262143, 23'd6553600, 23'd6452224, 24'd6452224}},
         '{18'd0,      18'd262143, 1'b1, '{18'd0,      23'd16,      23'd0,       24'd8}},
         '{18'd262143, 18'd0,      1'b1, '{18'd0,      23'd16,      23'd0,       24'd8}},
         '{18'd63,     18'd64,     1'b0, '0},
         '{18'd64,     18'd63,     1'b0, '0},
         '{18'd5,      18'd9,      1'b0, '0},
         '{18'd9,      18'd5,      1'b0, '0},
         '{18'd0,      18'd63,     1'b0, '0},
         '{18'd128,    18'd191,    1'b0, '0},
         '{18'd100,    18'd100,    1'b0, '0},
         '{18'd262080, 18'd262143, 1'b0, '0},
         '{18'd262079, 18'd262080, 1'b0, '0},
         '{18'd1,      18'd65,     1'b0, '0},
         '{18'd63,     18'd127,    1'b0, '0},
         '{18'd64,     18'd128,    1'b0, '0},
         '{18'd0,      18'd1,      1'b0, '0},
         '{18'd131072, 18'd131071, 1'b0, '0},
         '{18'h2AAAA,  18'h15555,  1'b0, '0},
         '{18'h15555,  18'h2AAAA,  1'b0, '0},
         '{18'd40,     18'd4135,   1'b0, '0},
         '{18'd10,     18'd70,     1'b0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_pair(directed_rows[i].a, directed_rows[i].b, directed_rows[i].typed,
                   directed_rows[i].want);
         pace_sender();
      end
      drain_results();

      // random pairs, mostly shaped towards the interesting cases
      for (int n = 0; n < RANDOM_PAIRS; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               a = $urandom_range(0, COORD_MAX);
               b = $urandom_range(0, COORD_MAX);
            end
            3, 4: begin
               // both inside one pixel
               a = $urandom_range(0, COORD_MAX) & ~(SUB_ONE - 1);
               b = a | $urandom_range(0, SUB_ONE - 1);
               a = a | $urandom_range(0, SUB_ONE - 1);
            end
            5: begin
               a = $urandom_range(0, COORD_MAX);
               b = a;
            end
            6, 7, 9: begin
               // short or medium spans, often crossing a boundary
               delta = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4096)
                                                   : $urandom_range(1, 200);
               a = $urandom_range(0, COORD_MAX);
               b = (a > COORD_MAX - delta) ? a - delta : a + delta;
            end
            default: begin
               // near the coordinate ends
               a = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                        : COORD_MAX - $urandom_range(0, 127);
               b = $urandom_range(0, 1) ? $urandom_range(0, 127)
                                        : COORD_MAX - $urandom_range(0, 127);
            end
         endcase
         if ($urandom_range(0, 1)) begin
            tmp = a;
            a = b;
            b = tmp;
         end
         send_pair(a[COORD_BITS-1:0], b[COORD_BITS-1:0], 1'b0, '0);
         if (n == RANDOM_PAIRS / 2)
            drain_results();
         else
            pace_sender();
      end

      drain_results();
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("edge_coverage_setup_top_tb OK");
      end else begin
         $display("edge_coverage_setup_top_tb NOT OK");
      end
      $finish;
   end

endmodule
